// ===== rtl/bdq_pkg.sv =====
`timescale 1ns / 1ps
// bdq_pkg: shared types and constants for the bounded deque.
// No dependencies; used by every other file of the block.
package bdq_pkg;

	localparam int WORD_W        = 32;
	localparam int DEPTH_DEFAULT = 1024;

	localparam logic [WORD_W-1:0] WORD_ALL_ONES = '1;
	localparam logic [WORD_W-1:0] WORD_ONE      = WORD_W'(1);
	localparam logic [WORD_W-1:0] WORD_ZERO     = '0;

	typedef enum logic [2:0] {
		CMD_PUSH_HEAD = 3'd0,
		CMD_PUSH_TAIL = 3'd1,
		CMD_POP_HEAD  = 3'd2,
		CMD_POP_TAIL  = 3'd3,
		CMD_SIZE      = 3'd4,
		CMD_EMPTY     = 3'd5,
		CMD_FRONT     = 3'd6,
		CMD_BACK      = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cycle operation of one chain of cells
	typedef enum logic [1:0] {
		CH_HOLD = 2'd0,
		CH_PUSH = 2'd1,  // each cell takes its lower neighbor, cell 0 takes word
		CH_PULL = 2'd2,  // each cell takes its upper neighbor
		CH_LOAD = 2'd3   // the selected cell takes word
	} chain_op_t;

	typedef struct packed {
		chain_op_t         op;
		logic [WORD_W-1:0] word;
	} chain_cmd_t;

endpackage

// ===== rtl/bdq_in_if.sv =====
`timescale 1ns / 1ps
// bdq_in_if: command channel of the bounded deque (valid/ready + cmd, value).
// Depends on bdq_pkg.
interface bdq_in_if;
	logic                              valid;
	logic                              ready;
	bdq_pkg::cmd_t                     cmd;
	logic signed [bdq_pkg::WORD_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== rtl/bdq_out_if.sv =====
`timescale 1ns / 1ps
// bdq_out_if: result channel of the bounded deque (valid/ready + status, data).
// Depends on bdq_pkg.
interface bdq_out_if;
	logic                              valid;
	logic                              ready;
	bdq_pkg::status_t                  status;
	logic signed [bdq_pkg::WORD_W-1:0] data;

	modport source (output valid, output status, output data, input ready);
	modport sink   (input valid, input status, input data, output ready);
endinterface

// ===== rtl/bdq_cell.sv =====
`timescale 1ns / 1ps
// bdq_cell: one word of a deque chain; loads from either neighbor or the bus.
// Depends on bdq_pkg.
module bdq_cell (
	input  logic                          clk,
	input  bdq_pkg::chain_cmd_t           cmd,
	input  logic                          sel,
	input  logic [bdq_pkg::WORD_W-1:0]    prev_word,
	input  logic [bdq_pkg::WORD_W-1:0]    next_word,
	output logic [bdq_pkg::WORD_W-1:0]    word
);

	logic [bdq_pkg::WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			bdq_pkg::CH_PUSH: word_q <= prev_word;
			bdq_pkg::CH_PULL: word_q <= next_word;
			bdq_pkg::CH_LOAD: begin
				if (sel) begin
					word_q <= cmd.word;
				end
			end
			default: ;
		endcase
	end

	assign word = word_q;

endmodule

// ===== rtl/bdq_chain.sv =====
`timescale 1ns / 1ps
// bdq_chain: row of DEPTH cells holding the deque in one reading direction.
// Depends on bdq_pkg and bdq_cell.
module bdq_chain #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  bdq_pkg::chain_cmd_t        cmd,
	input  logic [CW-1:0]              idx,
	output logic [bdq_pkg::WORD_W-1:0] head
);

	logic [bdq_pkg::WORD_W-1:0] words [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [bdq_pkg::WORD_W-1:0] prev_word;
		logic [bdq_pkg::WORD_W-1:0] next_word;

		if (i == 0) begin : g_first
			assign prev_word = cmd.word;
		end else begin : g_mid
			assign prev_word = words[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_word = words[i];
		end else begin : g_inner
			assign next_word = words[i+1];
		end

		bdq_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.sel       (idx == CW'(i)),
			.prev_word (prev_word),
			.next_word (next_word),
			.word      (words[i])
		);
	end

	assign head = words[0];

endmodule

// ===== rtl/bounded_deque.sv =====
`timescale 1ns / 1ps
// bounded_deque: top level of a bounded double-ended queue of 32-bit words.
// Depends on bdq_pkg, bdq_in_if, bdq_out_if and bdq_chain.
//
// Usage: commands arrive on req (cmd, value) and results leave on rsp
// (status, data), both valid/ready; a transfer happens when both are high.
// A push that fits gives no result; every other command gives one result.
// Storage is two rows of DEPTH cells: one keeps the elements front first,
// the other back first, so both ends always sit in cell 0 of a row. Every
// command does at most one neighbor shift or one decoded cell load per row.
// The result of a command is registered into the rsp register at the req
// transfer. Throughput: one command per cycle unless rsp stalls a result.
// The result register decouples the sides: req stays ready while rsp is
// being taken in the same cycle; when rsp stalls with a result pending,
// req is held off until that result transfers.
// Reset (arst_n low) empties the deque and drops any pending result; the
// cell contents are not cleared and are never read before being written.
module bounded_deque #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	bdq_in_if.sink          req,
	bdq_out_if.source       rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = bdq_pkg::WORD_W;

	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       cnt_nxt;
	logic                is_empty;
	logic                is_full;
	logic                accept;

	bdq_pkg::chain_cmd_t fwd_cmd;
	bdq_pkg::chain_cmd_t rev_cmd;
	logic [WW-1:0]       fwd_head;
	logic [WW-1:0]       rev_head;

	logic                res_valid;
	bdq_pkg::status_t    res_status;
	logic [WW-1:0]       res_data;

	logic                rsp_valid_q;
	bdq_pkg::status_t    rsp_status_q;
	logic [WW-1:0]       rsp_data_q;

	assign is_empty  = (cnt_q == '0);
	assign is_full   = (cnt_q == CW'(DEPTH));
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	always_comb begin
		fwd_cmd.op   = bdq_pkg::CH_HOLD;
		fwd_cmd.word = req.value;
		rev_cmd.op   = bdq_pkg::CH_HOLD;
		rev_cmd.word = req.value;
		cnt_nxt      = cnt_q;
		res_valid    = 1'b0;
		res_status   = bdq_pkg::ST_OK;
		res_data     = bdq_pkg::WORD_ZERO;

		case (req.cmd)
			bdq_pkg::CMD_PUSH_HEAD: begin
				if (is_full) begin
					res_valid  = 1'b1;
					res_status = bdq_pkg::ST_FULL;
				end else begin
					fwd_cmd.op = bdq_pkg::CH_PUSH;
					rev_cmd.op = bdq_pkg::CH_LOAD;
					cnt_nxt    = cnt_q + CW'(1);
				end
			end
			bdq_pkg::CMD_PUSH_TAIL: begin
				if (is_full) begin
					res_valid  = 1'b1;
					res_status = bdq_pkg::ST_FULL;
				end else begin
					fwd_cmd.op = bdq_pkg::CH_LOAD;
					rev_cmd.op = bdq_pkg::CH_PUSH;
					cnt_nxt    = cnt_q + CW'(1);
				end
			end
			bdq_pkg::CMD_POP_HEAD: begin
				res_valid = 1'b1;
				if (is_empty) begin
					res_status = bdq_pkg::ST_EMPTY;
					res_data   = bdq_pkg::WORD_ALL_ONES;
				end else begin
					res_data   = fwd_head;
					fwd_cmd.op = bdq_pkg::CH_PULL;
					cnt_nxt    = cnt_q - CW'(1);
				end
			end
			bdq_pkg::CMD_POP_TAIL: begin
				res_valid = 1'b1;
				if (is_empty) begin
					res_status = bdq_pkg::ST_EMPTY;
					res_data   = bdq_pkg::WORD_ALL_ONES;
				end else begin
					res_data   = rev_head;
					rev_cmd.op = bdq_pkg::CH_PULL;
					cnt_nxt    = cnt_q - CW'(1);
				end
			end
			bdq_pkg::CMD_SIZE: begin
				res_valid = 1'b1;
				res_data  = WW'(cnt_q);
			end
			bdq_pkg::CMD_EMPTY: begin
				res_valid = 1'b1;
				res_data  = is_empty ? bdq_pkg::WORD_ONE : bdq_pkg::WORD_ZERO;
			end
			bdq_pkg::CMD_FRONT: begin
				res_valid = 1'b1;
				if (is_empty) begin
					res_status = bdq_pkg::ST_EMPTY;
					res_data   = bdq_pkg::WORD_ALL_ONES;
				end else begin
					res_data = fwd_head;
				end
			end
			bdq_pkg::CMD_BACK: begin
				res_valid = 1'b1;
				if (is_empty) begin
					res_status = bdq_pkg::ST_EMPTY;
					res_data   = bdq_pkg::WORD_ALL_ONES;
				end else begin
					res_data = rev_head;
				end
			end
			default: ;
		endcase

		if (!accept) begin
			fwd_cmd.op = bdq_pkg::CH_HOLD;
			rev_cmd.op = bdq_pkg::CH_HOLD;
		end
	end

	// front-first row
	bdq_chain #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_fwd (
		.clk  (clk),
		.cmd  (fwd_cmd),
		.idx  (cnt_q),
		.head (fwd_head)
	);

	// back-first row
	bdq_chain #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_rev (
		.clk  (clk),
		.cmd  (rev_cmd),
		.idx  (cnt_q),
		.head (rev_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_nxt;
				rsp_valid_q <= res_valid;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			rsp_status_q <= res_status;
			rsp_data_q   <= res_data;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.data   = rsp_data_q;

endmodule

// ===== rtl/bdq_chk.sv =====
`timescale 1ns / 1ps
// bdq_chk: port-level checks for bounded_deque, bound to the top level.
// Depends on bdq_pkg and bounded_deque.
module bdq_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input bdq_pkg::cmd_t              req_cmd,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input bdq_pkg::status_t           rsp_status,
	input logic [bdq_pkg::WORD_W-1:0] rsp_data
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_data))
		else $error("bdq: stalled result changed");

	// no result pending means commands are taken
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("bdq: req not ready with empty result register");

	// every non-push transfer gives a result in the next cycle
	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_cmd != bdq_pkg::CMD_PUSH_HEAD
			&& req_cmd != bdq_pkg::CMD_PUSH_TAIL |=> rsp_valid)
		else $error("bdq: missing result after command");

	// empty answers carry -1, full answers carry 0
	a_status_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status != bdq_pkg::ST_EMPTY || rsp_data == bdq_pkg::WORD_ALL_ONES)
			&& (rsp_status != bdq_pkg::ST_FULL || rsp_data == bdq_pkg::WORD_ZERO))
		else $error("bdq: status and data disagree");

endmodule

bind bounded_deque bdq_chk u_bdq_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_cmd    (req.cmd),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_data   (rsp.data)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for bounded_deque with randomized valid/ready gaps.
// Depends on bdq_pkg, bdq_in_if, bdq_out_if and the bounded_deque RTL.
module tb_top;

	localparam int DEQUE_DEPTH  = bdq_pkg::DEPTH_DEFAULT;
	localparam int RANDOM_ITEMS = 1030;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 10;

	typedef struct {
		bdq_pkg::status_t           status;
		logic [bdq_pkg::WORD_W-1:0] data;
	} reply_t;

	class deque_scoreboard;
		int                         depth;
		int                         errors;
		logic [bdq_pkg::WORD_W-1:0] contents[$];
		reply_t                     awaited_replies[$];

		function new(int d);
			depth  = d;
			errors = 0;
		endfunction

		function int pending();
			return awaited_replies.size();
		endfunction

		function void note_command(bdq_pkg::cmd_t c, logic [bdq_pkg::WORD_W-1:0] v);
			reply_t r;
			bit     gives;
			gives    = 1'b1;
			r.status = bdq_pkg::ST_OK;
			r.data   = bdq_pkg::WORD_ZERO;
			case (c)
				bdq_pkg::CMD_PUSH_HEAD, bdq_pkg::CMD_PUSH_TAIL: begin
					if (contents.size() >= depth) begin
						r.status = bdq_pkg::ST_FULL;
					end else begin
						gives = 1'b0;
						if (c == bdq_pkg::CMD_PUSH_HEAD)
							contents.insert(0, v);
						else
							contents.insert(contents.size(), v);
					end
				end
				bdq_pkg::CMD_SIZE:  r.data = bdq_pkg::WORD_W'(contents.size());
				bdq_pkg::CMD_EMPTY: begin
					r.data = (contents.size() == 0) ? bdq_pkg::WORD_ONE : bdq_pkg::WORD_ZERO;
				end
				default: begin
					if (contents.size() == 0) begin
						r.status = bdq_pkg::ST_EMPTY;
						r.data   = bdq_pkg::WORD_ALL_ONES;
					end else begin
						case (c)
							bdq_pkg::CMD_POP_HEAD: begin
								r.data = contents[0];
								contents.delete(0);
							end
							bdq_pkg::CMD_POP_TAIL: begin
								r.data = contents[$];
								contents.delete(contents.size() - 1);
							end
							bdq_pkg::CMD_FRONT: r.data = contents[0];
							default:            r.data = contents[$];
						endcase
					end
				end
			endcase
			if (gives)
				awaited_replies.insert(awaited_replies.size(), r);
		endfunction

		function void check_result(bdq_pkg::status_t s, logic [bdq_pkg::WORD_W-1:0] d);
			reply_t r;
			if (awaited_replies.size() == 0) begin
				$error("unexpected result: status %0d data %0d", s, $signed(d));
				errors++;
				return;
			end
			r = awaited_replies[0];
			awaited_replies.delete(0);
			if (s !== r.status) begin
				$error("status mismatch: expected %0d, got %0d", r.status, s);
				errors++;
			end
			if (d !== r.data) begin
				$error("data mismatch: expected %0d, got %0d", $signed(r.data), $signed(d));
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	int   idle_cycles = 0;

	deque_scoreboard book = new(DEQUE_DEPTH);

	bdq_in_if  req_ch ();
	bdq_out_if rsp_ch ();

	bounded_deque #(.DEPTH(DEQUE_DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				book.check_result(rsp_ch.status, rsp_ch.data);
			if (req_ch.valid && req_ch.ready)
				book.note_command(req_ch.cmd, req_ch.value);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// result side: random stall before each transfer
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	task automatic issue_command(bdq_pkg::cmd_t c, logic [bdq_pkg::WORD_W-1:0] v);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd   <= c;
		req_ch.value <= v;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
	endtask

	function automatic bdq_pkg::cmd_t pick_range(bdq_pkg::cmd_t lo, bdq_pkg::cmd_t hi);
		return bdq_pkg::cmd_t'($urandom_range(int'(lo), int'(hi)));
	endfunction

	// mode 0 fills, mode 1 drains, mode 2 mixes evenly
	function automatic bdq_pkg::cmd_t pick_cmd(int mode);
		int r;
		r = $urandom_range(0, 9);
		case (mode)
			0: begin
				if (r < 8)
					return pick_range(bdq_pkg::CMD_PUSH_HEAD, bdq_pkg::CMD_PUSH_TAIL);
				return pick_range(bdq_pkg::CMD_POP_HEAD, bdq_pkg::CMD_BACK);
			end
			1: begin
				if (r < 6)
					return pick_range(bdq_pkg::CMD_POP_HEAD, bdq_pkg::CMD_POP_TAIL);
				else if (r < 8)
					return pick_range(bdq_pkg::CMD_SIZE, bdq_pkg::CMD_BACK);
				return pick_range(bdq_pkg::CMD_PUSH_HEAD, bdq_pkg::CMD_PUSH_TAIL);
			end
			default: return pick_range(bdq_pkg::CMD_PUSH_HEAD, bdq_pkg::CMD_BACK);
		endcase
	endfunction

	function automatic logic [bdq_pkg::WORD_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return bdq_pkg::WORD_ALL_ONES;
			1:       return 32'h8000_0000;
			2:       return 32'h7FFF_FFFF;
			3:       return bdq_pkg::WORD_ZERO;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int sent;
		int mode;
		int len;
		req_ch.valid <= 1'b0;
		req_ch.cmd   <= bdq_pkg::CMD_SIZE;
		req_ch.value <= bdq_pkg::WORD_ZERO;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty store: every read reports empty
		issue_command(bdq_pkg::CMD_POP_HEAD, bdq_pkg::WORD_ZERO);
		issue_command(bdq_pkg::CMD_POP_TAIL, bdq_pkg::WORD_ALL_ONES);
		issue_command(bdq_pkg::CMD_FRONT, bdq_pkg::WORD_ZERO);
		issue_command(bdq_pkg::CMD_BACK, bdq_pkg::WORD_ZERO);
		issue_command(bdq_pkg::CMD_SIZE, bdq_pkg::WORD_ZERO);
		issue_command(bdq_pkg::CMD_EMPTY, bdq_pkg::WORD_ZERO);
		// extremes at both ends
		issue_command(bdq_pkg::CMD_PUSH_TAIL, 32'h7FFF_FFFF);
		issue_command(bdq_pkg::CMD_PUSH_HEAD, 32'h8000_0000);
		issue_command(bdq_pkg::CMD_PUSH_TAIL, bdq_pkg::WORD_ZERO);
		issue_command(bdq_pkg::CMD_PUSH_HEAD, bdq_pkg::WORD_ALL_ONES);
		issue_command(bdq_pkg::CMD_FRONT, bdq_pkg::WORD_ZERO);
		issue_command(bdq_pkg::CMD_BACK, bdq_pkg::WORD_ZERO);
		issue_command(bdq_pkg::CMD_SIZE, bdq_pkg::WORD_ZERO);
		issue_command(bdq_pkg::CMD_EMPTY, bdq_pkg::WORD_ZERO);
		issue_command(bdq_pkg::CMD_POP_HEAD, bdq_pkg::WORD_ZERO);
		issue_command(bdq_pkg::CMD_POP_TAIL, bdq_pkg::WORD_ZERO);
		issue_command(bdq_pkg::CMD_POP_HEAD, bdq_pkg::WORD_ZERO);
		issue_command(bdq_pkg::CMD_POP_TAIL, bdq_pkg::WORD_ZERO);
		issue_command(bdq_pkg::CMD_EMPTY, bdq_pkg::WORD_ZERO);
		issue_command(bdq_pkg::CMD_BACK, bdq_pkg::WORD_ZERO);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 2);
			len  = $urandom_range(8, 40);
			calm = ($urandom_range(0, 3) == 0);
			repeat (len) begin
				issue_command(pick_cmd(mode), pick_value());
				sent++;
			end
		end
		req_ch.valid <= 1'b0;
		calm = 1'b0;

		while (book.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.errors == 0 && book.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/bdq_pkg.sv
rtl/bdq_in_if.sv
rtl/bdq_out_if.sv
rtl/bdq_cell.sv
rtl/bdq_chain.sv
rtl/bounded_deque.sv
rtl/bdq_chk.sv
test/tb_top.sv
